// File: hdl/rmfa_pkg.sv
// rmfa_pkg: shared types, constants and helpers for the rotation matrix block
// no dependencies

package rmfa_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 34;
    localparam int PHASE_W      = 20;
    localparam int Z_W          = 20;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [23:0] PHASE_K = 24'sd2670177;
    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

    typedef enum logic [2:0] {
        KIND_XYZ  = 3'd0,
        KIND_ZXY  = 3'd1,
        KIND_AXIS = 3'd2,
        KIND_ROTX = 3'd3,
        KIND_ROTY = 3'd4,
        KIND_ROTZ = 3'd5,
        KIND_ID6  = 3'd6,
        KIND_ID7  = 3'd7
    } kind_t;

    // per-stage state of one cordic lane
    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [Z_W-1:0]      z;
        logic [1:0]                 quad;
    } cordic_st_t;

    // sine and cosine in q2.14
    typedef struct packed {
        logic signed [15:0] s;
        logic signed [15:0] c;
    } sincos_t;

    function automatic logic [Z_W-1:0] atan_turns(input int i);
        case (i)
            0:  atan_turns = 20'd131072;
            1:  atan_turns = 20'd77376;
            2:  atan_turns = 20'd40884;
            3:  atan_turns = 20'd20753;
            4:  atan_turns = 20'd10417;
            5:  atan_turns = 20'd5213;
            6:  atan_turns = 20'd2607;
            7:  atan_turns = 20'd1304;
            8:  atan_turns = 20'd652;
            9:  atan_turns = 20'd326;
            10: atan_turns = 20'd163;
            11: atan_turns = 20'd81;
            12: atan_turns = 20'd41;
            13: atan_turns = 20'd20;
            14: atan_turns = 20'd10;
            15: atan_turns = 20'd5;
            default: atan_turns = 20'd0;
        endcase
    endfunction

    // round with half added, floor shift by 16, saturate to +-1.0
    function automatic logic signed [15:0] rnd16(input logic signed [CORDIC_W:0] v);
        logic signed [CORDIC_W:0] t;
        logic signed [CORDIC_W-16:0] r;
        begin
            t = v + (CORDIC_W+1)'(32768);
            r = t[CORDIC_W:16];
            if (r > 19'sd16384)
                rnd16 = Q14_ONE;
            else if (r < -19'sd16384)
                rnd16 = -Q14_ONE;
            else
                rnd16 = r[15:0];
        end
    endfunction

    // round with half added, floor shift by 28, saturate to +-1.0
    function automatic logic signed [15:0] rnd28(input logic signed [51:0] v);
        logic signed [51:0] t;
        logic signed [23:0] r;
        begin
            t = v + 52'sd134217728;
            r = t[51:28];
            if (r > 24'sd16384)
                rnd28 = Q14_ONE;
            else if (r < -24'sd16384)
                rnd28 = -Q14_ONE;
            else
                rnd28 = r[15:0];
        end
    endfunction

endpackage

// File: hdl/rotation_matrix_from_angles.sv
// rotation_matrix_from_angles: top level, three cordic lanes and a merging stage
// depends on rmfa_pkg, rmfa_cordic, rmfa_merge
//
//  port group    dir  handshake          payload
//  in            in   in_valid/in_ready  kind, angle_x..z, axis_x..z
//  out           out  out_valid/out_ready m11..m33
//
// one word per cycle while the output is not stalled; the pipeline registers are phase multiply,
// lane start, 16 cordic stages, fold/round, two product stages and final round
// the whole pipeline advances only when the output register is free or taken
// reset clears valid flags only; data registers carry no reset

`default_nettype none

module rotation_matrix_from_angles (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         kind,
    input  wire logic signed [15:0] angle_x,
    input  wire logic signed [15:0] angle_y,
    input  wire logic signed [15:0] angle_z,
    input  wire logic signed [15:0] axis_x,
    input  wire logic signed [15:0] axis_y,
    input  wire logic signed [15:0] axis_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      m11,
    output logic signed [15:0]      m12,
    output logic signed [15:0]      m13,
    output logic signed [15:0]      m21,
    output logic signed [15:0]      m22,
    output logic signed [15:0]      m23,
    output logic signed [15:0]      m31,
    output logic signed [15:0]      m32,
    output logic signed [15:0]      m33
);
    import rmfa_pkg::*;

    localparam int CORDIC_LAT = CORDIC_STEPS + 3;
    localparam int LAT = CORDIC_LAT + 3;

    logic               en;
    logic [LAT-1:0]     vld_reg;
    logic [LAT-1:0]     vld_next;
    logic [2:0]         kind_d_reg [CORDIC_LAT];
    logic signed [15:0] ax_d_reg [CORDIC_LAT];
    logic signed [15:0] ay_d_reg [CORDIC_LAT];
    logic signed [15:0] az_d_reg [CORDIC_LAT];
    sincos_t            sc_x, sc_y, sc_z;
    logic signed [15:0] m [9];

    // stall-all pipeline: advance when the last word is absent or leaving
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_d_reg[0] <= kind;
            ax_d_reg[0]   <= axis_x;
            ay_d_reg[0]   <= axis_y;
            az_d_reg[0]   <= axis_z;
            for (int i = 1; i < CORDIC_LAT; i++)
            begin
                kind_d_reg[i] <= kind_d_reg[i-1];
                ax_d_reg[i]   <= ax_d_reg[i-1];
                ay_d_reg[i]   <= ay_d_reg[i-1];
                az_d_reg[i]   <= az_d_reg[i-1];
            end
        end
    end

    rmfa_cordic u_lane_x (.clk(clk), .en(en), .angle(angle_x), .result(sc_x));
    rmfa_cordic u_lane_y (.clk(clk), .en(en), .angle(angle_y), .result(sc_y));
    rmfa_cordic u_lane_z (.clk(clk), .en(en), .angle(angle_z), .result(sc_z));

    rmfa_merge u_merge (
        .clk  (clk),
        .en   (en),
        .kind (kind_d_reg[CORDIC_LAT-1]),
        .sc_x (sc_x),
        .sc_y (sc_y),
        .sc_z (sc_z),
        .ax   (ax_d_reg[CORDIC_LAT-1]),
        .ay   (ay_d_reg[CORDIC_LAT-1]),
        .az   (az_d_reg[CORDIC_LAT-1]),
        .m    (m)
    );

    assign out_valid = vld_reg[LAT-1];
    assign m11 = m[0]; assign m12 = m[1]; assign m13 = m[2];
    assign m21 = m[3]; assign m22 = m[4]; assign m23 = m[5];
    assign m31 = m[6]; assign m32 = m[7]; assign m33 = m[8];

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("ready low with empty output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(m11) && $stable(m33))
        else $error("output word changed while stalled");
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (m11 <= 16'sd16384 && m11 >= -16'sd16384))
        else $error("element out of range");

endmodule

`default_nettype wire

// File: hdl/rmfa_cordic.sv
// rmfa_cordic: pipelined sine/cosine lane, angle q4.12 radians in, q2.14 out
// depends on rmfa_pkg

`default_nettype none

module rmfa_cordic (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [15:0]   angle,
    output rmfa_pkg::sincos_t         result
);
    import rmfa_pkg::*;

    logic signed [39:0]         prod_reg;
    logic signed [39:0]         prod_next;
    cordic_st_t                 st_reg [CORDIC_STEPS+1];
    cordic_st_t                 st_next [CORDIC_STEPS+1];
    logic signed [CORDIC_W:0]   c_w;
    logic signed [CORDIC_W:0]   s_w;
    sincos_t                    res_reg;
    sincos_t                    res_next;
    logic [39:0]                tph;

    assign prod_next = 40'(angle) * 40'(PHASE_K) + 40'sd32768;

    always_comb
    begin
        tph = prod_reg;
        st_next[0].x    = CORDIC_X0;
        st_next[0].y    = '0;
        st_next[0].quad = tph[35:34];
        st_next[0].z    = {2'b00, tph[33:16]};
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!st_reg[i].z[Z_W-1])
            begin
                st_next[i+1].x = st_reg[i].x - (st_reg[i].y >>> i);
                st_next[i+1].y = st_reg[i].y + (st_reg[i].x >>> i);
                st_next[i+1].z = st_reg[i].z - atan_turns(i);
            end
            else
            begin
                st_next[i+1].x = st_reg[i].x + (st_reg[i].y >>> i);
                st_next[i+1].y = st_reg[i].y - (st_reg[i].x >>> i);
                st_next[i+1].z = st_reg[i].z + atan_turns(i);
            end
            st_next[i+1].quad = st_reg[i].quad;
        end
    end

    // quadrant fold
    always_comb
    begin
        case (st_reg[CORDIC_STEPS].quad)
            2'd0:
            begin
                c_w = 35'(st_reg[CORDIC_STEPS].x);
                s_w = 35'(st_reg[CORDIC_STEPS].y);
            end
            2'd1:
            begin
                c_w = -35'(st_reg[CORDIC_STEPS].y);
                s_w = 35'(st_reg[CORDIC_STEPS].x);
            end
            2'd2:
            begin
                c_w = -35'(st_reg[CORDIC_STEPS].x);
                s_w = -35'(st_reg[CORDIC_STEPS].y);
            end
            default:
            begin
                c_w = 35'(st_reg[CORDIC_STEPS].y);
                s_w = -35'(st_reg[CORDIC_STEPS].x);
            end
        endcase
        res_next.c = rnd16(c_w);
        res_next.s = rnd16(s_w);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            for (int i = 0; i <= CORDIC_STEPS; i++)
                st_reg[i] <= st_next[i];
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

// File: hdl/rmfa_merge.sv
// rmfa_merge: combines the three lanes' sines and cosines into the nine elements
// depends on rmfa_pkg

`default_nettype none

module rmfa_merge (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [2:0]           kind,
    input  rmfa_pkg::sincos_t         sc_x,
    input  rmfa_pkg::sincos_t         sc_y,
    input  rmfa_pkg::sincos_t         sc_z,
    input  wire logic signed [15:0]   ax,
    input  wire logic signed [15:0]   ay,
    input  wire logic signed [15:0]   az,
    output logic signed [15:0]        m [9]
);
    import rmfa_pkg::*;

    // stage a: pair products (q4.28), stage b: triple terms (q42), stage c: round
    logic signed [31:0] p_reg [12];
    logic signed [31:0] p_next [12];
    logic signed [16:0] f_reg [12];
    logic signed [16:0] f_next [12];
    logic signed [16:0] g_reg [9];
    logic signed [16:0] g_next [9];
    logic signed [51:0] t_reg [9];
    logic signed [51:0] t_next [9];
    logic signed [15:0] m_reg [9];
    logic signed [15:0] m_next [9];
    logic [2:0]         kind_reg;
    logic signed [15:0] sx, cx, sy, cy, sz, cz;
    logic signed [16:0] omc;

    assign sx = sc_x.s; assign cx = sc_x.c;
    assign sy = sc_y.s; assign cy = sc_y.c;
    assign sz = sc_z.s; assign cz = sc_z.c;
    assign omc = 17'sd16384 - 17'(cx);

    // each element sums p*f terms and g*2^28, where p is a product of two q14 values
    always_comb
    begin
        for (int i = 0; i < 12; i++)
        begin
            p_next[i] = '0;
            f_next[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            g_next[i] = '0;
        case (kind)
            KIND_XYZ:
            begin
                p_next[0] = cy * cz;  f_next[0] = 17'sd16384;
                p_next[1] = cy * sz;  f_next[1] = 17'sd16384;
                g_next[2] = -17'(sy);
                p_next[3] = sx * sy;  f_next[3] = 17'(cz);
                p_next[9] = cx * sz;  f_next[9] = -17'sd16384;
                p_next[4] = sx * sy;  f_next[4] = 17'(sz);
                p_next[10] = cx * cz; f_next[10] = 17'sd16384;
                p_next[5] = sx * cy;  f_next[5] = 17'sd16384;
                p_next[6] = cx * sy;  f_next[6] = 17'(cz);
                p_next[11] = sx * sz; f_next[11] = 17'sd16384;
                p_next[7] = cx * sy;  f_next[7] = 17'(sz);
                // slot 2 is free here, it carries the second term of m32
                p_next[2] = sx * cz;  f_next[2] = -17'sd16384;
                p_next[8] = cx * cy;  f_next[8] = 17'sd16384;
            end
            KIND_ZXY:
            begin
                p_next[0] = cz * cy;  f_next[0] = 17'sd16384;
                p_next[9] = sz * sx;  f_next[9] = 17'(sy);
                p_next[1] = sz * cx;  f_next[1] = 17'sd16384;
                p_next[2] = cz * sy;  f_next[2] = -17'sd16384;
                p_next[10] = sz * sx; f_next[10] = 17'(cy);
                p_next[3] = sz * cy;  f_next[3] = -17'sd16384;
                p_next[11] = cz * sx; f_next[11] = 17'(sy);
                p_next[4] = cz * cx;  f_next[4] = 17'sd16384;
                p_next[5] = sz * sy;  f_next[5] = 17'sd16384;
                // slot 7 is free here, it carries the second term of m23
                p_next[7] = cz * sx;  f_next[7] = 17'(cy);
                p_next[6] = cx * sy;  f_next[6] = 17'sd16384;
                g_next[7] = -17'(sx);
                p_next[8] = cx * cy;  f_next[8] = 17'sd16384;
            end
            KIND_AXIS:
            begin
                p_next[0] = ax * ax; f_next[0] = omc; g_next[0] = 17'(cx);
                p_next[1] = ax * ay; f_next[1] = omc;
                p_next[2] = az * ax; f_next[2] = omc;
                p_next[3] = ax * ay; f_next[3] = omc;
                p_next[4] = ay * ay; f_next[4] = omc; g_next[4] = 17'(cx);
                p_next[5] = ay * az; f_next[5] = omc;
                p_next[6] = az * ax; f_next[6] = omc;
                p_next[7] = ay * az; f_next[7] = omc;
                p_next[8] = az * az; f_next[8] = omc; g_next[8] = 17'(cx);
                p_next[9] = az * sx;  f_next[9] = 17'sd16384;
                p_next[10] = ay * sx; f_next[10] = 17'sd16384;
                p_next[11] = ax * sx; f_next[11] = 17'sd16384;
            end
            KIND_ROTX:
            begin
                g_next[0] = 17'sd16384;
                g_next[4] = 17'(cx); g_next[5] = 17'(sx);
                g_next[7] = -17'(sx); g_next[8] = 17'(cx);
            end
            KIND_ROTY:
            begin
                g_next[4] = 17'sd16384;
                g_next[0] = 17'(cx); g_next[2] = -17'(sx);
                g_next[6] = 17'(sx); g_next[8] = 17'(cx);
            end
            KIND_ROTZ:
            begin
                g_next[8] = 17'sd16384;
                g_next[0] = 17'(cx); g_next[1] = 17'(sx);
                g_next[3] = -17'(sx); g_next[4] = 17'(cx);
            end
            default:
            begin
                g_next[0] = 17'sd16384; g_next[4] = 17'sd16384; g_next[8] = 17'sd16384;
            end
        endcase
    end

    // second product stage: route extra products to their elements by kind, then round the registered sums
    always_comb
    begin
        logic signed [51:0] e [12];
        for (int i = 0; i < 12; i++)
            e[i] = 52'(p_reg[i]) * 52'(f_reg[i]);
        for (int i = 0; i < 9; i++)
            t_next[i] = e[i] + (52'(g_reg[i]) <<< 28);
        case (kind_reg)
            KIND_XYZ:
            begin
                t_next[2] = 52'(g_reg[2]) <<< 28;
                t_next[3] = e[3] + e[9];
                t_next[4] = e[4] + e[10];
                t_next[6] = e[6] + e[11];
                t_next[7] = e[7] + e[2];
            end
            KIND_ZXY:
            begin
                t_next[0] = e[0] + e[9];
                t_next[2] = e[2] + e[10];
                t_next[3] = e[3] + e[11];
                t_next[5] = e[5] + e[7];
                t_next[7] = 52'(g_reg[7]) <<< 28;
            end
            KIND_AXIS:
            begin
                t_next[1] = e[1] + e[9];
                t_next[2] = e[2] - e[10];
                t_next[3] = e[3] - e[9];
                t_next[5] = e[5] + e[11];
                t_next[6] = e[6] + e[10];
                t_next[7] = e[7] - e[11];
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < 9; i++)
            m_next[i] = rnd28(t_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 12; i++)
            begin
                p_reg[i] <= p_next[i];
                f_reg[i] <= f_next[i];
            end
            g_reg    <= g_next;
            kind_reg <= kind;
            t_reg    <= t_next;
            m_reg    <= m_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            m[i] = m_reg[i];
    end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking bench for rotation_matrix_from_angles, random and directed words
// depends on rmfa_pkg and the rotation_matrix_from_angles rtl

`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rmfa_pkg::*;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] ang_x;
        logic signed [15:0] ang_y;
        logic signed [15:0] ang_z;
        logic signed [15:0] ax_x;
        logic signed [15:0] ax_y;
        logic signed [15:0] ax_z;
    } request_t;

    // element 0 is m11, element 8 is m33
    typedef logic [8:0][15:0] matrix_t;

    localparam longint ONE = 16384;
    localparam longint ARCTAN [16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607,
                                       1304, 652, 326, 163, 81, 41, 20, 10, 5};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] kind = '0;
    logic signed [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
    logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;

    request_t request_q[$];
    matrix_t  matrix_q[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  mismatches = 0;
    int  words_in = 0;
    int  words_out = 0;
    int  kind_seen[8];
    bit  in_fire = 1'b0;

    rotation_matrix_from_angles DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .m11(m11), .m12(m12), .m13(m13), .m21(m21), .m22(m22), .m23(m23),
        .m31(m31), .m32(m32), .m33(m33)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint round_clamp(longint v, int sh);
        longint r;
        begin
            r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
            if (r > ONE)
                r = ONE;
            if (r < -ONE)
                r = -ONE;
            return r;
        end
    endfunction

    task automatic sin_cos(input logic signed [15:0] a, output longint sn, output longint cs);
        longint t, ph, z, x, y, dx, dy, c, s;
        logic [1:0] quad;
        begin
            t = (longint'(a) * 2670177 + 32768) >>> 16;
            ph = t & 64'hFFFFF;
            quad = ph[19:18];
            z = ph & 64'h3FFFF;
            x = 652032874;
            y = 0;
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= ARCTAN[i];
                end
                else
                begin
                    x += dx; y -= dy; z += ARCTAN[i];
                end
            end
            case (quad)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
            cs = round_clamp(c, 16);
            sn = round_clamp(s, 16);
        end
    endtask

    task automatic rotation_of(input request_t r, output matrix_t res);
        longint m[9];
        longint sx, cx, sy, cy, sz, cz, ax, ay, az, omc, u;
        begin
            u = ONE;
            foreach (m[i])
                m[i] = 0;
            m[0] = u * u * u; m[4] = m[0]; m[8] = m[0];
            sin_cos(r.ang_x, sx, cx);
            sin_cos(r.ang_y, sy, cy);
            sin_cos(r.ang_z, sz, cz);
            ax = r.ax_x; ay = r.ax_y; az = r.ax_z;
            omc = u - cx;
            case (kind_t'(r.kind))
                KIND_XYZ:
                begin
                    m[0] = cy * cz * u;
                    m[1] = cy * sz * u;
                    m[2] = -sy * u * u;
                    m[3] = sx * sy * cz - cx * sz * u;
                    m[4] = sx * sy * sz + cx * cz * u;
                    m[5] = sx * cy * u;
                    m[6] = cx * sy * cz + sx * sz * u;
                    m[7] = cx * sy * sz - sx * cz * u;
                    m[8] = cx * cy * u;
                end
                KIND_ZXY:
                begin
                    m[0] = cz * cy * u + sz * sx * sy;
                    m[1] = sz * cx * u;
                    m[2] = -cz * sy * u + sz * sx * cy;
                    m[3] = -sz * cy * u + cz * sx * sy;
                    m[4] = cz * cx * u;
                    m[5] = sz * sy * u + cz * sx * cy;
                    m[6] = cx * sy * u;
                    m[7] = -sx * u * u;
                    m[8] = cx * cy * u;
                end
                KIND_AXIS:
                begin
                    m[0] = ax * ax * omc + cx * u * u;
                    m[1] = ax * ay * omc + az * sx * u;
                    m[2] = az * ax * omc - ay * sx * u;
                    m[3] = ax * ay * omc - az * sx * u;
                    m[4] = ay * ay * omc + cx * u * u;
                    m[5] = ay * az * omc + ax * sx * u;
                    m[6] = az * ax * omc + ay * sx * u;
                    m[7] = ay * az * omc - ax * sx * u;
                    m[8] = az * az * omc + cx * u * u;
                end
                KIND_ROTX:
                begin
                    m[4] = cx * u * u; m[5] = sx * u * u;
                    m[7] = -sx * u * u; m[8] = cx * u * u;
                end
                KIND_ROTY:
                begin
                    m[0] = cx * u * u; m[2] = -sx * u * u;
                    m[6] = sx * u * u; m[8] = cx * u * u;
                end
                KIND_ROTZ:
                begin
                    m[0] = cx * u * u; m[1] = sx * u * u;
                    m[3] = -sx * u * u; m[4] = cx * u * u;
                end
                default: ;
            endcase
            for (int i = 0; i < 9; i++)
                res[i] = 16'(round_clamp(m[i], 28));
        end
    endtask

    // sender: new word only once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                request_t r;
                r = request_q.pop_front();
                in_valid <= 1'b1;
                kind <= r.kind;
                angle_x <= r.ang_x; angle_y <= r.ang_y; angle_z <= r.ang_z;
                axis_x <= r.ax_x; axis_y <= r.ax_y; axis_z <= r.ax_z;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        matrix_t want, got;
        request_t r;
        in_fire = in_valid && in_ready;
        if (in_fire)
        begin
            r = '{kind, angle_x, angle_y, angle_z, axis_x, axis_y, axis_z};
            rotation_of(r, want);
            matrix_q.push_back(want);
            kind_seen[kind]++;
            words_in++;
        end
        if (out_valid && out_ready)
        begin
            got = {m33, m32, m31, m23, m22, m21, m13, m12, m11};
            words_out++;
            if (matrix_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with nothing outstanding", $realtime);
            end
            else
            begin
                want = matrix_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want[i])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: m%0d%0d expected %0d got %0d", $realtime,
                                     i / 3 + 1, i % 3 + 1, $signed(want[i]), $signed(got[i]));
                    end
            end
        end
    end

    function automatic logic signed [15:0] rand_axis();
        // mostly legal components, now and then any 16-bit value
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(25736)) - 12868);   // within +-pi
            2: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom_range(3) * 6434);           // near quadrant edges
        endcase
    endfunction

    task automatic add_random(int n);
        request_t r;
        begin
            repeat (n)
            begin
                r.kind = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                                   : 3'($urandom_range(5));
                r.ang_x = rand_angle();
                r.ang_y = rand_angle();
                r.ang_z = rand_angle();
                r.ax_x = rand_axis();
                r.ax_y = rand_axis();
                r.ax_z = rand_axis();
                if (r.kind == KIND_AXIS && $urandom_range(1))
                begin
                    // unit axis along one coordinate, sign random
                    r.ax_x = '0; r.ax_y = '0; r.ax_z = '0;
                    case ($urandom_range(2))
                        0: r.ax_x = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                        1: r.ax_y = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                        default: r.ax_z = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                    endcase
                end
                request_q.push_back(r);
            end
        end
    endtask

    task automatic drain();
        wait (request_q.size() == 0);
        @(posedge clk);
        while (in_valid || matrix_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        for (int k = 0; k < 8; k++)
        begin
            request_q.push_back('{3'(k), 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
            request_q.push_back('{3'(k), 16'sd32767, -16'sd32768, 16'sd6434,
                                  16'sd9459, 16'sd9459, -16'sd9459});
        end
        request_q.push_back('{KIND_XYZ, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd0});
        request_q.push_back('{KIND_ZXY, 16'sd6434, -16'sd6434, 16'sd12868, 16'sd0, 16'sd0, 16'sd0});
        // axis not unit: saturating elements
        request_q.push_back('{KIND_AXIS, 16'sd12868, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd32767});
        request_q.push_back('{KIND_AXIS, -16'sd6434, 16'sd0, 16'sd0, -16'sd16384, 16'sd16384, -16'sd1});
        request_q.push_back('{KIND_ROTX, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        request_q.push_back('{KIND_ROTZ, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        drain();

        // sender holds off here until the pipe is empty
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 46 : 38) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 46 : 38) : 0;
            add_random(470);
            drain();
        end

        repeat (40) @(posedge clk);
        $display("words in %0d, out %0d; per kind xyz %0d zxy %0d axis %0d x %0d y %0d z %0d",
                 words_in, words_out, kind_seen[0], kind_seen[1], kind_seen[2],
                 kind_seen[3], kind_seen[4], kind_seen[5]);
        $display("unused kinds %0d, four idle/stall phases, mismatches %0d",
                 kind_seen[6] + kind_seen[7], mismatches);
        if (mismatches == 0 && matrix_q.size() == 0)
            $display("** rotation_matrix_from_angles: PASSED **");
        else
            $display("** rotation_matrix_from_angles: FAILED **");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("timeout");
        $display("** rotation_matrix_from_angles: FAILED **");
        $finish;
    end

endmodule
